FILE: rtl/sbds_pkg.sv
package sbds_pkg;

    localparam int PIX_W     = 8;
    localparam int SHIFT_W   = 7;
    localparam int COST_W    = 24;
    localparam int COUNT_W   = 12;
    localparam int DISP_W    = 8;
    localparam int BLK_W     = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;
    localparam int OUT_W     = 32;

    localparam logic [COUNT_W-1:0]   COUNT_MAX = '1;
    localparam logic [COST_W-1:0]    COST_MAX  = '1;

    // divide by five: (x * 205) >> 10 is exact for x below 1024
    localparam logic [DISP_W-1:0]    DIV5_MUL   = 8'd205;
    localparam int                   DIV5_SHIFT = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK    = 1'b1;

    localparam logic [DISP_W-1:0]    RST_MAX_DISP = 8'd64;
    localparam logic [BLK_W-1:0]     RST_BLOCK    = 5'd16;

    typedef struct packed {
        logic start;     // clear best result
        logic wr_en;     // store one pixel
        logic issue;     // read one pixel pair
        logic first;     // pair opens a block
        logic last;      // pair closes a block
        logic load_out;  // move best result to the output register
    } t_cmd;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/sbds_ctrl.sv
module sbds_ctrl
    import sbds_pkg::*;
#(
    parameter int MAX_BLOCK   = 16,
    parameter int MAX_DISP    = 128,
    parameter int STORE_DEPTH = 2304,
    parameter int AW          = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_valid,
    input  logic                 i_last,
    output logic                 o_ready,
    input  t_sts                 i_sts,
    output t_cmd                 o_cmd,
    output logic [AW-1:0]        o_wr_addr,
    output logic [AW-1:0]        o_rd_addr_a,
    output logic [AW-1:0]        o_rd_addr_b,
    output logic [SHIFT_W-1:0]   o_shift
);

    localparam int CW = $clog2(MAX_BLOCK + 1);
    localparam int WW = DISP_W + 2;
    localparam int PW = CW + WW;

    localparam logic [1:0] ST_LOAD   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [DISP_W-1:0]  r_max_disp;
    logic [BLK_W-1:0]   r_block;
    logic [COUNT_W-1:0] r_load_cnt, n_load_cnt;
    logic [DISP_W-1:0]  r_t, n_t;
    logic [CW-1:0]      r_r, n_r;
    logic [CW-1:0]      r_c, n_c;
    logic [AW-1:0]      r_row_base, n_row_base;

    logic [CW-1:0]      b_eff;
    logic [DISP_W-1:0]  d_eff;
    logic [WW-1:0]      w;
    logic [PW-1:0]      bw;
    logic [DISP_W-1:0]  t_lo;
    logic [2*DISP_W-1:0] div_prod;
    logic               accept;
    logic               c_end, r_end;
    logic [AW-1:0]      ia;

    always_comb begin
        if (r_block == '0) begin
            b_eff = CW'(1);
        end else if (32'(r_block) > MAX_BLOCK) begin
            b_eff = CW'(MAX_BLOCK);
        end else begin
            b_eff = CW'(r_block);
        end
        if (32'(r_max_disp) > MAX_DISP) begin
            d_eff = DISP_W'(MAX_DISP);
        end else begin
            d_eff = r_max_disp;
        end
    end

    assign w        = WW'(b_eff) + WW'(d_eff);
    assign bw       = PW'(b_eff) * PW'(w);
    assign div_prod = (2*DISP_W)'(d_eff) * (2*DISP_W)'(DIV5_MUL);
    assign t_lo     = DISP_W'(div_prod >> DIV5_SHIFT);

    assign accept = i_valid && o_ready;
    assign c_end  = (r_c == b_eff - CW'(1));
    assign r_end  = (r_r == b_eff - CW'(1));
    assign ia     = AW'(32'(r_row_base) + 32'(r_c));

    assign o_ready     = (r_state == ST_LOAD);
    assign o_wr_addr   = AW'(r_load_cnt);
    assign o_rd_addr_a = ia;
    assign o_rd_addr_b = AW'(32'(ia) + 32'(r_t));
    assign o_shift     = r_t[SHIFT_W-1:0];

    always_comb begin
        n_state    = r_state;
        n_load_cnt = r_load_cnt;
        n_t        = r_t;
        n_r        = r_r;
        n_c        = r_c;
        n_row_base = r_row_base;
        o_cmd      = '0;
        case (r_state)
            ST_LOAD: begin
                if (accept) begin
                    o_cmd.wr_en = (32'(r_load_cnt) < 32'(bw)) &&
                                  (32'(r_load_cnt) < STORE_DEPTH);
                    if (r_load_cnt != COUNT_MAX) begin
                        n_load_cnt = r_load_cnt + COUNT_W'(1);
                    end
                    if (i_last) begin
                        o_cmd.start = 1'b1;
                        n_load_cnt  = '0;
                        n_t         = t_lo;
                        n_r         = '0;
                        n_c         = '0;
                        n_row_base  = '0;
                        n_state     = (t_lo < d_eff) ? ST_SEARCH : ST_DRAIN;
                    end
                end
            end
            ST_SEARCH: begin
                o_cmd.issue = 1'b1;
                o_cmd.first = (r_r == '0) && (r_c == '0);
                o_cmd.last  = r_end && c_end;
                if (c_end) begin
                    n_c = '0;
                    if (r_end) begin
                        n_r        = '0;
                        n_row_base = '0;
                        n_t        = r_t + DISP_W'(1);
                        if (r_t + DISP_W'(1) == d_eff) begin
                            n_state = ST_DRAIN;
                        end
                    end else begin
                        n_r        = r_r + CW'(1);
                        n_row_base = AW'(32'(r_row_base) + 32'(w));
                    end
                end else begin
                    n_c = r_c + CW'(1);
                end
            end
            ST_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_max_disp <= RST_MAX_DISP;
            r_block    <= RST_BLOCK;
            r_load_cnt <= '0;
            r_t        <= '0;
            r_r        <= '0;
            r_c        <= '0;
            r_row_base <= '0;
        end else begin
            r_state    <= n_state;
            r_load_cnt <= n_load_cnt;
            r_t        <= n_t;
            r_r        <= n_r;
            r_c        <= n_c;
            r_row_base <= n_row_base;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAX_DISP: r_max_disp <= i_cfg_data;
                    CFG_BLOCK:    r_block    <= i_cfg_data[BLK_W-1:0];
                    default:      r_block    <= r_block;
                endcase
            end
        end
    end

    a_last_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last) |=> (r_load_cnt == '0))
        else $error("load count not cleared after last pixel");

    a_no_load_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.pipe_busy |-> !o_ready)
        else $error("pixel request accepted while search pipeline busy");

    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_sts.out_free)
        else $error("result loaded over a waiting result");

    a_issue_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.issue |-> (r_t < d_eff) && (r_r < b_eff) && (r_c < b_eff))
        else $error("pair read outside the search range");

endmodule

FILE: rtl/sbds_dpath.sv
module sbds_dpath
    import sbds_pkg::*;
#(
    parameter int MAX_BLOCK   = 16,
    parameter int STORE_DEPTH = 2304,
    parameter int AW          = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [PIX_W-1:0]   i_pixel,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [AW-1:0]      i_rd_addr_a,
    input  logic [AW-1:0]      i_rd_addr_b,
    input  logic [SHIFT_W-1:0] i_shift,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [SHIFT_W-1:0] o_best_disparity,
    output logic [COST_W-1:0]  o_best_cost
);

    localparam int SQ_W   = 2 * PIX_W;
    localparam int SUM_MIN = SQ_W + 2 * $clog2(MAX_BLOCK);
    localparam int SUMW   = (SUM_MIN > COST_W) ? SUM_MIN : COST_W;

    logic [PIX_W-1:0] r_mem [STORE_DEPTH];

    logic [PIX_W-1:0]   r_rd_a, r_rd_b;
    logic               r_s1_valid, r_s1_first, r_s1_last;
    logic [SHIFT_W-1:0] r_s1_shift;
    logic               r_s2_valid, r_s2_first, r_s2_last;
    logic [SHIFT_W-1:0] r_s2_shift;
    logic [SQ_W-1:0]    r_s2_sq;
    logic [SUMW-1:0]    r_acc;
    logic [SUMW-1:0]    r_best;
    logic [SHIFT_W-1:0] r_best_shift;
    logic               r_out_valid;
    logic [SHIFT_W-1:0] r_out_disp;
    logic [COST_W-1:0]  r_out_cost;

    logic signed [PIX_W:0]     diff;
    logic signed [2*PIX_W+1:0] sq_full;
    logic [SUMW-1:0]           sum_n;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_addr] <= i_pixel;
        end
        if (i_cmd.issue) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign diff    = $signed({1'b0, r_rd_a}) - $signed({1'b0, r_rd_b});
    assign sq_full = diff * diff;
    assign sum_n   = r_s2_first ? SUMW'(r_s2_sq) : r_acc + SUMW'(r_s2_sq);

    always_ff @(posedge i_clk) begin
        r_s1_first <= i_cmd.first;
        r_s1_last  <= i_cmd.last;
        r_s1_shift <= i_shift;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_s2_shift <= r_s1_shift;
        r_s2_sq    <= sq_full[SQ_W-1:0];
        if (r_s2_valid) begin
            r_acc <= sum_n;
        end
        if (i_cmd.load_out) begin
            r_out_disp <= r_best_shift;
            r_out_cost <= (r_best > SUMW'(COST_MAX)) ? COST_MAX : r_best[COST_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_best       <= '1;
            r_best_shift <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.issue;
            r_s2_valid <= r_s1_valid;
            if (i_cmd.start) begin
                r_best       <= '1;
                r_best_shift <= '0;
            end else if (r_s2_valid && r_s2_last && (sum_n < r_best)) begin
                r_best       <= sum_n;
                r_best_shift <= r_s2_shift;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.pipe_busy = r_s1_valid || r_s2_valid;
    assign o_sts.out_free  = !r_out_valid || i_ready;

    assign o_valid          = r_out_valid;
    assign o_best_disparity = r_out_disp;
    assign o_best_cost      = r_out_cost;

    a_best_only_falls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_cmd.start && !$past(i_cmd.start)) |-> (r_best <= $past(r_best)))
        else $error("best cost rose during a search");

    a_drained_before_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> !r_s1_valid && !r_s2_valid)
        else $error("result loaded while pairs still in flight");

    a_no_read_write_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.issue |-> !i_cmd.wr_en)
        else $error("pixel store written during the search");

endmodule

FILE: rtl/ssd_block_disparity_search.sv
// SSD block-matching disparity search for one strip of B rows by B+D columns of 8-bit
// pixels (B the block side, D = max_disparity). Pixels stream in row-major at one per
// cycle while s_axis_tready is high into an on-chip strip memory; the request carrying
// tlast starts the search. The search walks every shift from floor(D/5) to D-1, reading
// one pixel pair per cycle from the two read ports of the strip memory, then drains the
// square-and-sum pipeline and loads the result. New pixels are refused from the last
// pixel until the result sits in the output register; a result waiting there does not
// block loading. The strip memory needs no clearing after reset. m_axis_tdata:
// best_disparity [6:0], best_cost [30:7] (saturated at all ones, all ones with shift 0
// for an empty range).
module ssd_block_disparity_search
    import sbds_pkg::*;
#(
    parameter int MAX_BLOCK = 16,
    parameter int MAX_DISP  = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [PIX_W-1:0]     s_axis_tdata,   // pixel
    input  logic                 s_axis_tlast,   // last_pixel
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_W-1:0]     m_axis_tdata    // best_disparity, best_cost, zero pad
);

    localparam int STORE_DEPTH = MAX_BLOCK * (MAX_BLOCK + MAX_DISP);
    localparam int AW          = $clog2(STORE_DEPTH);

    t_cmd               cmd;
    t_sts               sts;
    logic [AW-1:0]      wr_addr, rd_addr_a, rd_addr_b;
    logic [SHIFT_W-1:0] shift;
    logic [SHIFT_W-1:0] best_disparity;
    logic [COST_W-1:0]  best_cost;

    sbds_ctrl #(
        .MAX_BLOCK   (MAX_BLOCK),
        .MAX_DISP    (MAX_DISP),
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .i_last      (s_axis_tlast),
        .o_ready     (s_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_wr_addr   (wr_addr),
        .o_rd_addr_a (rd_addr_a),
        .o_rd_addr_b (rd_addr_b),
        .o_shift     (shift)
    );

    sbds_dpath #(
        .MAX_BLOCK   (MAX_BLOCK),
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_pixel          (s_axis_tdata),
        .i_wr_addr        (wr_addr),
        .i_rd_addr_a      (rd_addr_a),
        .i_rd_addr_b      (rd_addr_b),
        .i_shift          (shift),
        .o_valid          (m_axis_tvalid),
        .i_ready          (m_axis_tready),
        .o_best_disparity (best_disparity),
        .o_best_cost      (best_cost)
    );

    assign m_axis_tdata = {{(OUT_W - SHIFT_W - COST_W){1'b0}}, best_cost, best_disparity};

endmodule
